// ===== design/aspl_pkg.sv =====
// shared types and constants for the aligned slab page layout core
// no dependencies; imported by every module of the block

package aspl_pkg;

   localparam int SLAB_COUNT_DEF   = 64;
   localparam int OFFSET_WIDTH_DEF = 48;

   localparam int NUM_REGIONS  = 4;
   localparam int REGION_W     = 2;
   localparam int ALIGN_W      = 5;
   localparam int SLAB_IDX_W   = 6;
   localparam int SIZE_W       = 32;
   localparam int COUNT_W      = 16;
   localparam int CLASS_W      = 16;
   localparam int OFF_OUT_W    = 48;
   localparam int ADDR_W       = 64;
   localparam int CSR_IDX_W    = 4;

   localparam int REQ_TDATA_W  = 80;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_TDATA_W  = 168;

   typedef enum logic [1:0] {
      OP_HEADER = 2'd0,
      OP_SLAB   = 2'd1,
      OP_PAGE   = 2'd2
   } op_type;

   // one request after the input register, with the header product precomputed
   typedef struct packed {
      op_type                 op;
      logic                   in_range;
      logic                   cnt_zero;
      logic [REGION_W-1:0]    region;
      logic [ALIGN_W-1:0]     align;
      logic [SIZE_W-1:0]      dsize;
      logic [SIZE_W-1:0]      product;
   } item_type;

   // result fields, lowest field in the lowest bits
   typedef struct packed {
      logic                   overflow;
      logic                   skipped;
      logic                   is_header_page;
      logic [ALIGN_W-1:0]     region_align_log2;
      logic [OFF_OUT_W-1:0]   region_total;
      logic [ADDR_W-1:0]      address;
      logic [OFF_OUT_W-1:0]   offset;
   } rsp_type;

   // state update strobes from the calculation unit
   typedef struct packed {
      logic                   size_we;
      logic                   align_we;
      logic                   slab_we;
      logic [REGION_W-1:0]    region;
      logic [ALIGN_W-1:0]     align;
      logic [REGION_W-1:0]    slab_region;
   } upd_type;

endpackage

// ===== design/aspl_calc.sv =====
// placement arithmetic for one request: align up, saturating add, max alignment
// depends on aspl_pkg

module aspl_calc
   import aspl_pkg::*;
#(
   parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
   input  item_type                 item_i,
   input  logic [OFFSET_WIDTH-1:0]  region_size_i  [NUM_REGIONS],
   input  logic [ALIGN_W-1:0]       region_align_i [NUM_REGIONS],
   input  logic [ADDR_W-1:0]        base_i         [NUM_REGIONS],
   input  logic [REGION_W-1:0]      slab_region_i,
   input  logic [OFFSET_WIDTH-1:0]  slab_cursor_i,
   output rsp_type                  rsp_o,
   output upd_type                  upd_o,
   output logic [OFFSET_WIDTH-1:0]  new_size_o,
   output logic [OFFSET_WIDTH-1:0]  new_cursor_o
);

   localparam logic [OFFSET_WIDTH-1:0] LIMIT = {OFFSET_WIDTH{1'b1}};

   logic [REGION_W-1:0]     sel;
   logic [OFFSET_WIDTH-1:0] cur_size;
   logic [ALIGN_W-1:0]      cur_align;
   logic [ADDR_W-1:0]       base;
   logic [OFFSET_WIDTH-1:0] cursor;
   logic [OFFSET_WIDTH-1:0] mask;
   logic [OFFSET_WIDTH:0]   asum;
   logic                    a_ovf;
   logic [OFFSET_WIDTH-1:0] aligned;
   logic [SIZE_W-1:0]       grow_by;
   logic [OFFSET_WIDTH:0]   bsum;
   logic                    b_ovf;
   logic [OFFSET_WIDTH-1:0] grown;
   logic [ALIGN_W-1:0]      max_align;

   // region that the request touches
   always_comb begin
      case (item_i.op)
         OP_HEADER: sel = '0;
         OP_SLAB:   sel = item_i.region;
         default:   sel = slab_region_i;
      endcase
   end

   assign cur_size  = region_size_i[sel];
   assign cur_align = region_align_i[sel];
   assign base      = base_i[sel];
   assign cursor    = (item_i.op == OP_PAGE) ? slab_cursor_i : cur_size;

   // align up, saturating on carry out
   assign mask    = (OFFSET_WIDTH'(1) << item_i.align) - OFFSET_WIDTH'(1);
   assign asum    = {1'b0, cursor} + {1'b0, mask};
   assign a_ovf   = asum[OFFSET_WIDTH];
   assign aligned = a_ovf ? LIMIT : (asum[OFFSET_WIDTH-1:0] & ~mask);

   // advance by the item size
   assign grow_by = (item_i.op == OP_HEADER) ? item_i.product : item_i.dsize;
   assign bsum    = {1'b0, aligned} + {1'b0, OFFSET_WIDTH'(grow_by)};
   assign b_ovf   = bsum[OFFSET_WIDTH];
   assign grown   = b_ovf ? LIMIT : bsum[OFFSET_WIDTH-1:0];

   assign max_align = (item_i.align > cur_align) ? item_i.align : cur_align;

   always_comb begin
      rsp_o        = '0;
      upd_o        = '0;
      upd_o.region = sel;
      upd_o.align  = max_align;
      new_size_o   = grown;
      new_cursor_o = '0;
      unique case (item_i.op)
         OP_HEADER: begin
            if (item_i.cnt_zero) begin
               rsp_o.skipped           = 1'b1;
               rsp_o.region_total      = OFF_OUT_W'(cur_size);
               rsp_o.region_align_log2 = cur_align;
            end else begin
               rsp_o.offset            = OFF_OUT_W'(aligned);
               rsp_o.region_total      = OFF_OUT_W'(grown);
               rsp_o.region_align_log2 = max_align;
               rsp_o.overflow          = a_ovf | b_ovf;
               upd_o.size_we           = 1'b1;
               upd_o.align_we          = 1'b1;
            end
         end
         OP_SLAB: begin
            if (item_i.in_range) begin
               upd_o.slab_we     = 1'b1;
               upd_o.slab_region = item_i.region;
               if (item_i.region != '0) begin
                  new_cursor_o            = aligned;
                  rsp_o.offset            = OFF_OUT_W'(aligned);
                  rsp_o.region_total      = OFF_OUT_W'(grown);
                  rsp_o.region_align_log2 = max_align;
                  rsp_o.overflow          = a_ovf | b_ovf;
                  upd_o.size_we           = 1'b1;
                  upd_o.align_we          = 1'b1;
               end else begin
                  rsp_o.region_total      = OFF_OUT_W'(cur_size);
                  rsp_o.region_align_log2 = cur_align;
               end
            end
         end
         OP_PAGE: begin
            if (item_i.in_range) begin
               rsp_o.region_align_log2 = cur_align;
               if (slab_region_i == '0) begin
                  // header page: region 0 base, nothing moves
                  rsp_o.is_header_page = 1'b1;
                  rsp_o.address        = base;
               end else begin
                  rsp_o.offset       = OFF_OUT_W'(aligned);
                  rsp_o.address      = base + ADDR_W'(aligned);
                  rsp_o.region_total = OFF_OUT_W'(grown);
                  rsp_o.overflow     = a_ovf | b_ovf;
                  upd_o.slab_we      = 1'b1;
                  upd_o.slab_region  = slab_region_i;
                  new_cursor_o       = grown;
               end
            end
         end
         default: begin
            rsp_o = '0;
         end
      endcase
   end

endmodule

// ===== design/aligned_slab_page_layout_core.sv =====
// top level of the aligned slab page layout core: two-level aligned bump allocator
// depends on aspl_pkg and aspl_calc
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  req_     | in        | tvalid / tready    | tuser op, tdata request fields
//  rsp_     | out       | tvalid / tready    | tdata result fields
//  csr_     | in        | valid / ready      | index, data (region base addresses)
//
//  one transaction per cycle sustained while rsp_tready is high; a result passes the input
//  register and then the output register after its request is accepted
//  the slab table read is registered at acceptance, a bypass covers the write of
//  the request just ahead, so back to back requests on the same slab need no bubble
//  reset clears the region cursors, alignments, base registers and all valid flags;
//  the slab table has no clear and must be written by a slab record before a page uses it
//  a stalled result holds in the output register; the stage behind it then fills and
//  req_tready drops only when both are occupied

module aligned_slab_page_layout_core
   import aspl_pkg::*;
#(
   parameter int SLAB_COUNT   = SLAB_COUNT_DEF,
   parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // request
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // slab_index, region, align_log2, data_size, asset_count, class_size, zero pad
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   // op
   input  logic [REQ_TUSER_W-1:0]  req_tuser,
   // result
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // offset, address, region_total, region_align_log2, is_header_page, skipped, overflow
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   // configuration
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [ADDR_W-1:0]       csr_data
);

   localparam int SLAB_AW = (SLAB_COUNT > 1) ? $clog2(SLAB_COUNT) : 1;
   localparam int ENTRY_W = OFFSET_WIDTH + REGION_W;

   // request field unpacking
   logic [SLAB_IDX_W-1:0] f_slab;
   logic [REGION_W-1:0]   f_region;
   logic [ALIGN_W-1:0]    f_align;
   logic [SIZE_W-1:0]     f_dsize;
   logic [COUNT_W-1:0]    f_count;
   logic [CLASS_W-1:0]    f_class;

   assign f_slab   = req_tdata[5:0];
   assign f_region = req_tdata[7:6];
   assign f_align  = req_tdata[12:8];
   assign f_dsize  = req_tdata[44:13];
   assign f_count  = req_tdata[60:45];
   assign f_class  = req_tdata[76:61];

   // handshake
   logic req_fire;
   logic fire;

   // input stage
   logic                 s1_valid_ff, s1_valid_in;
   item_type             s1_item_ff, s1_item_in;
   logic [SLAB_AW-1:0]   s1_addr_ff, s1_addr_in;

   // slab table with registered read and a one-entry write bypass
   logic [ENTRY_W-1:0]   slab_mem [SLAB_COUNT];
   logic [ENTRY_W-1:0]   rd_ff;
   logic                 byp_valid_ff;
   logic [SLAB_AW-1:0]   byp_addr_ff;
   logic [ENTRY_W-1:0]   byp_data_ff;
   logic [ENTRY_W-1:0]   entry;
   logic [ENTRY_W-1:0]   wr_entry;

   // region state and configuration
   logic [OFFSET_WIDTH-1:0] region_size_ff  [NUM_REGIONS];
   logic [ALIGN_W-1:0]      region_align_ff [NUM_REGIONS];
   logic [ADDR_W-1:0]       base_ff         [NUM_REGIONS];

   // calculation results
   rsp_type                 calc_rsp;
   upd_type                 calc_upd;
   logic [OFFSET_WIDTH-1:0] calc_size;
   logic [OFFSET_WIDTH-1:0] calc_cursor;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff;

   // the input stage moves on when the output register is free or emptying
   assign fire       = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | fire;
   assign req_fire   = req_tvalid & req_tready;

   assign csr_ready  = 1'b1;

   always_comb begin
      s1_item_in          = s1_item_ff;
      s1_addr_in          = s1_addr_ff;
      s1_valid_in         = s1_valid_ff;
      if (req_fire) begin
         s1_item_in.op       = op_type'(req_tuser);
         s1_item_in.in_range = (32'(f_slab) < SLAB_COUNT);
         s1_item_in.cnt_zero = (f_count == '0);
         s1_item_in.region   = f_region;
         s1_item_in.align    = f_align;
         s1_item_in.dsize    = f_dsize;
         // header growth precomputed ahead of the cursor arithmetic
         s1_item_in.product  = SIZE_W'(f_count) * SIZE_W'(f_class);
         s1_addr_in          = SLAB_AW'(f_slab);
         s1_valid_in         = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGIONS; i++) begin
            region_size_ff[i]  <= '0;
            region_align_ff[i] <= '0;
            base_ff[i]         <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire && calc_upd.size_we) begin
            region_size_ff[calc_upd.region] <= calc_size;
         end
         if (fire && calc_upd.align_we) begin
            region_align_ff[calc_upd.region] <= calc_upd.align;
         end
         if (fire && calc_upd.slab_we) begin
            byp_valid_ff <= 1'b1;
         end
         // user writes configuration while idle, unchecked; indexes past the list drop
         if (csr_valid && csr_ready && (32'(csr_index) < NUM_REGIONS)) begin
            base_ff[csr_index[REGION_W-1:0]] <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      s1_addr_ff <= s1_addr_in;
      if (fire) begin
         rsp_data_ff <= calc_rsp;
      end
      if (fire && calc_upd.slab_we) begin
         byp_addr_ff <= s1_addr_ff;
         byp_data_ff <= wr_entry;
      end
   end

   // slab table: read on acceptance, write when the owning request completes
   assign wr_entry = {calc_upd.slab_region, calc_cursor};

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= slab_mem[SLAB_AW'(f_slab)];
      end
      if (fire && calc_upd.slab_we) begin
         slab_mem[s1_addr_ff] <= wr_entry;
      end
   end

   // the last write may postdate the read of the request now in the stage
   assign entry = (byp_valid_ff && (byp_addr_ff == s1_addr_ff)) ? byp_data_ff : rd_ff;

   aspl_calc #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_calc (
      .item_i         (s1_item_ff),
      .region_size_i  (region_size_ff),
      .region_align_i (region_align_ff),
      .base_i         (base_ff),
      .slab_region_i  (entry[ENTRY_W-1:OFFSET_WIDTH]),
      .slab_cursor_i  (entry[OFFSET_WIDTH-1:0]),
      .rsp_o          (calc_rsp),
      .upd_o          (calc_upd),
      .new_size_o     (calc_size),
      .new_cursor_o   (calc_cursor)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/aspl_checker.sv =====
// port-level checks on the result channel of the aligned slab page layout core
// depends on aspl_pkg; bound to aligned_slab_page_layout_core

module aspl_checker
   import aspl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RSP_TDATA_W-1:0]  rsp_tdata
);

   rsp_type rsp;

   assign rsp = rsp_tdata;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // nothing is offered in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered straight after reset");

   // a skipped header record places nothing
   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.skipped |-> rsp.offset == '0 && rsp.address == '0 && !rsp.overflow
         && !rsp.is_header_page)
      else $error("skipped record carries a placement");

   // a header page has no offset and no cursor
   a_header_page: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.is_header_page |-> rsp.offset == '0 && rsp.region_total == '0
         && !rsp.overflow && !rsp.skipped)
      else $error("header page with placement data");

endmodule

bind aligned_slab_page_layout_core aspl_checker u_checker (.*);
